FILE: hw/rtl/gbjf_pkg.sv
// ----------------------------------------------------------------------------
// gbjf_pkg
// shared types, constants and the arctangent table of the base jump filter
// ----------------------------------------------------------------------------
package gbjf_pkg;

   localparam int XW       = 36;   // cordic datapath width
   localparam int MW       = 34;   // multiplier operand width
   localparam int PW       = 2 * MW;
   localparam int SW       = 62;   // square root radicand width
   localparam int RW       = 31;   // square root result width
   localparam int ATAB_LEN = 48;
   localparam int ATAB_IW  = 6;
   localparam int CORDIC_ITER_DEFAULT = 32;

   localparam logic signed [XW-1:0] Q30_ONE     = 36'sd1073741824;
   localparam logic signed [XW-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [XW-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [XW-1:0] CORDIC_KINV = 36'sd652032874;
   localparam logic signed [MW-1:0] DEG7_TO_RAD = 34'sd503056908;
   localparam logic signed [MW-1:0] EARTH_DIAM  = 34'sd12756274;
   localparam logic [24:0]          DIST_MAX    = 25'd20037509;
   localparam logic signed [30:0]   MIN_VALID_LAT = 31'sd1000000;
   localparam logic signed [31:0]   MIN_VALID_LNG = 32'sd1000000;
   localparam logic signed [30:0]   MIN_PRIOR     = 31'sd10000000;
   localparam logic [15:0]          LIMIT_RESET   = 16'd1000;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_LOCK   = 2'd1,
      OP_UNLOCK = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_ACCEPT  = 2'd0,
      ST_INVALID = 2'd1,
      ST_JUMP    = 2'd2,
      ST_NOP     = 2'd3
   } status_type;

   typedef struct packed {
      logic load;
      logic vectoring;
   } cordic_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_stat_type;

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_RAD_MUL   = 13'b0000000000010,
      S_RAD_FIX   = 13'b0000000000100,
      S_ROT_WAIT  = 13'b0000000001000,
      S_PROD_MUL  = 13'b0000000010000,
      S_PROD_WB   = 13'b0000000100000,
      S_SQRT_GO   = 13'b0000001000000,
      S_SQRT_WAIT = 13'b0000010000000,
      S_VEC_GO    = 13'b0000100000000,
      S_VEC_WAIT  = 13'b0001000000000,
      S_DIST_MUL  = 13'b0010000000000,
      S_DIST_FIX  = 13'b0100000000000,
      S_FINISH    = 13'b1000000000000
   } fsm_type;

   // atan(2^-i) in q30
   function automatic logic signed [XW-1:0] atab_value(input logic [ATAB_IW-1:0] idx);
      logic signed [XW-1:0] v;
      case (idx)
         6'd0:  v = 36'sd843314856;
         6'd1:  v = 36'sd497837829;
         6'd2:  v = 36'sd263043836;
         6'd3:  v = 36'sd133525158;
         6'd4:  v = 36'sd67021686;
         6'd5:  v = 36'sd33543515;
         6'd6:  v = 36'sd16775850;
         6'd7:  v = 36'sd8388437;
         6'd8:  v = 36'sd4194282;
         6'd9:  v = 36'sd2097149;
         6'd10: v = 36'sd1048575;
         6'd11: v = 36'sd524287;
         6'd12: v = 36'sd262143;
         6'd13: v = 36'sd131071;
         6'd14: v = 36'sd65535;
         6'd15: v = 36'sd32767;
         6'd16: v = 36'sd16383;
         6'd17: v = 36'sd8191;
         6'd18: v = 36'sd4095;
         6'd19: v = 36'sd2047;
         6'd20: v = 36'sd1023;
         6'd21: v = 36'sd511;
         6'd22: v = 36'sd255;
         6'd23: v = 36'sd127;
         6'd24: v = 36'sd63;
         6'd25: v = 36'sd31;
         6'd26: v = 36'sd15;
         6'd27: v = 36'sd7;
         6'd28: v = 36'sd3;
         6'd29: v = 36'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/gbjf_if.sv
// ----------------------------------------------------------------------------
// gbjf channel interfaces
// request, response and register write channels of the base jump filter
// ----------------------------------------------------------------------------
interface gbjf_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [30:0] lat_in;
   logic signed [31:0] lng_in;
   modport source (output valid, operation, lat_in, lng_in, input ready);
   modport sink   (input valid, operation, lat_in, lng_in, output ready);
endinterface

interface gbjf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [30:0] eff_lat;
   logic signed [31:0] eff_lng;
   logic [1:0]         status;
   logic               is_locked;
   logic [24:0]        jump_m;
   modport source (output valid, eff_lat, eff_lng, status, is_locked, jump_m, input ready);
   modport sink   (input valid, eff_lat, eff_lng, status, is_locked, jump_m, output ready);
endinterface

interface gbjf_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] jump_limit_m;
   modport source (output valid, jump_limit_m, input ready);
   modport sink   (input valid, jump_limit_m, output ready);
endinterface

FILE: hw/rtl/gbjf_mul.sv
// ----------------------------------------------------------------------------
// gbjf_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module gbjf_mul
   import gbjf_pkg::*;
(
   input  logic                 clock,
   input  logic signed [MW-1:0] a_in,
   input  logic signed [MW-1:0] b_in,
   output logic signed [PW-1:0] p_out
);

   logic signed [PW-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= a_in * b_in;
   end

   assign p_out = p_ff;

endmodule

FILE: hw/rtl/gbjf_isqrt.sv
// ----------------------------------------------------------------------------
// gbjf_isqrt
// floor integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module gbjf_isqrt
   import gbjf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [SW-1:0] v_in,
   output logic          done,
   output logic          busy,
   output logic [RW-1:0] root
);

   logic [SW-1:0] rem_ff, r_ff, bit_ff;
   logic          busy_ff, done_ff;
   logic [SW-1:0] rb;

   assign rb = r_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff == SW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= v_in;
         r_ff   <= '0;
         bit_ff <= SW'(1) << (SW - 2);
      end else if (busy_ff) begin
         if (rem_ff >= rb) begin
            rem_ff <= rem_ff - rb;
            r_ff   <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff   <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign busy = busy_ff;
   assign root = r_ff[RW-1:0];

endmodule

FILE: hw/rtl/gbjf_cordic.sv
// ----------------------------------------------------------------------------
// gbjf_cordic
// shared cordic, rotation mode for sine and cosine, vectoring mode for atan2
// ----------------------------------------------------------------------------
module gbjf_cordic
   import gbjf_pkg::*;
#(
   parameter int ITERATIONS = CORDIC_ITER_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  cordic_ctrl_type      ctrl,
   input  logic signed [XW-1:0] x_in,
   input  logic signed [XW-1:0] y_in,
   input  logic signed [XW-1:0] z_in,
   output cordic_stat_type      stat,
   output logic signed [XW-1:0] sin_out,
   output logic signed [XW-1:0] cos_out,
   output logic signed [XW-1:0] angle_out
);

   localparam int CW = $clog2(ITERATIONS);
   localparam logic [CW-1:0] LAST = CW'(ITERATIONS - 1);

   logic signed [XW-1:0] x_ff, y_ff, z_ff;
   logic                 neg_ff, vec_ff, busy_ff, done_ff;
   logic [CW-1:0]        iter_ff;
   logic signed [XW-1:0] dx, dy, a;
   logic                 sigma;

   assign dx    = y_ff >>> iter_ff;
   assign dy    = x_ff >>> iter_ff;
   assign a     = atab_value(ATAB_IW'(iter_ff));
   // rotate towards z = 0 or towards y = 0
   assign sigma = vec_ff ? !(y_ff > 0) : (z_ff >= 0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.load) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && iter_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         iter_ff <= '0;
         vec_ff  <= ctrl.vectoring;
         if (ctrl.vectoring) begin
            x_ff   <= x_in;
            y_ff   <= y_in;
            z_ff   <= '0;
            neg_ff <= 1'b0;
         end else begin
            x_ff <= CORDIC_KINV;
            y_ff <= '0;
            // fold into the right half plane
            if (z_in > Q30_HALF_PI) begin
               z_ff   <= z_in - Q30_PI;
               neg_ff <= 1'b1;
            end else if (z_in < -Q30_HALF_PI) begin
               z_ff   <= z_in + Q30_PI;
               neg_ff <= 1'b1;
            end else begin
               z_ff   <= z_in;
               neg_ff <= 1'b0;
            end
         end
      end else if (busy_ff) begin
         iter_ff <= iter_ff + CW'(1);
         if (sigma) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - a;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + a;
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign sin_out   = neg_ff ? -y_ff : y_ff;
   assign cos_out   = neg_ff ? -x_ff : x_ff;
   assign angle_out = z_ff;

endmodule

FILE: hw/rtl/gnss_base_jump_filter_core.sv
// ----------------------------------------------------------------------------
// gnss_base_jump_filter_core
// qualifies base-station gnss fixes by a haversine jump test, keeps live and
// locked base positions
// ----------------------------------------------------------------------------
// one request transfer gives exactly one response transfer. lock, unlock,
// invalid fixes and updates with no prior fix (live latitude not above one
// degree) go straight to the finish state. an update against a prior fix
// computes the great-circle distance on one shared cordic, one shared
// multiplier and one bit-serial square root: four sine/cosine rotations,
// two square roots, one vectoring pass and nine multiply steps. one request
// is worked on at a time; the finished response sits in an output register,
// so the next request transfer is taken while it waits. jump_limit_m is
// written over the csr channel, which is always ready and must only be used
// while idle.
// ----------------------------------------------------------------------------
module gnss_base_jump_filter_core
   import gbjf_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEFAULT
)(
   input  logic       clock,
   input  logic       reset,
   gbjf_req_if.sink   req_bus,
   gbjf_rsp_if.source rsp_bus,
   gbjf_csr_if.sink   csr_bus
);

   // sequencer
   fsm_type state_ff, state_in;
   logic [1:0] k_ff;       // angle being converted
   logic [1:0] pstep_ff;   // product step of the haversine term
   logic       sq_sel_ff;  // second square root

   // request and persistent state
   logic [1:0]         op_ff;
   logic signed [30:0] lat_ff;
   logic signed [31:0] lng_ff;
   logic signed [30:0] live_lat_ff, snap_lat_ff;
   logic signed [31:0] live_lng_ff, snap_lng_ff;
   logic               lock_ff;
   logic [15:0]        limit_ff;

   // intermediate values
   logic signed [MW-1:0] s0_ff, s1_ff, c2_ff, c3_ff, t1_ff, t2_ff;
   logic [RW-1:0]        h_ff, ry_ff, rx_ff;
   logic [30:0]          theta_ff;
   logic [24:0]          jump_ff;

   // response register
   logic               rsp_valid_ff;
   logic signed [30:0] rsp_lat_ff;
   logic signed [31:0] rsp_lng_ff;
   status_type         rsp_status_ff;
   logic               rsp_lock_ff;
   logic [24:0]        rsp_jump_ff;

   logic req_fire, fin_fire, need_dist, fix_valid, detour;

   // shared units
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   cordic_ctrl_type      cordic_ctrl;
   cordic_stat_type      cordic_stat;
   logic signed [XW-1:0] cx_in, cy_in, cz_in, c_sin, c_cos, c_angle;
   logic                 sq_start, sq_done, sq_busy;
   logic [SW-1:0]        sq_v;
   logic [RW-1:0]        sq_root;

   gbjf_mul u_mul (
      .clock (clock),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .p_out (mul_p)
   );

   gbjf_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cordic_ctrl),
      .x_in      (cx_in),
      .y_in      (cy_in),
      .z_in      (cz_in),
      .stat      (cordic_stat),
      .sin_out   (c_sin),
      .cos_out   (c_cos),
      .angle_out (c_angle)
   );

   gbjf_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .v_in  (sq_v),
      .done  (sq_done),
      .busy  (sq_busy),
      .root  (sq_root)
   );

   // first visit of the finish state for an update that needs a distance
   assign detour = (state_ff == S_FINISH) && jump_ff == '0 && need_dist &&
                   k_ff == 2'd0 && !sq_sel_ff;

   // handshakes
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign fin_fire      = (state_ff == S_FINISH) && !detour &&
                          (!rsp_valid_ff || rsp_bus.ready);

   // a valid fix needs both coordinates at or above 0.1 degree
   assign fix_valid = (lat_ff >= MIN_VALID_LAT) && (lng_ff >= MIN_VALID_LNG);
   // distance only once a live fix above one degree latitude exists
   assign need_dist = (op_ff == OP_UPDATE) && fix_valid && (live_lat_ff > MIN_PRIOR);

   // angle differences and absolutes, degrees times 1e7
   logic signed [MW-1:0] ang_val, ang_mag;
   logic                 ang_neg;
   always_comb begin
      case (k_ff)
         2'd0:    ang_val = MW'(lat_ff) - MW'(live_lat_ff);
         2'd1:    ang_val = MW'(lng_ff) - MW'(live_lng_ff);
         2'd2:    ang_val = MW'(lat_ff);
         default: ang_val = MW'(live_lat_ff);
      endcase
   end
   assign ang_neg = ang_val[MW-1];
   assign ang_mag = ang_neg ? -ang_val : ang_val;

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_RAD_MUL) begin
         mul_a = ang_mag;
         mul_b = DEG7_TO_RAD;
      end else if (state_ff == S_PROD_MUL) begin
         case (pstep_ff)
            2'd0:    begin mul_a = c2_ff; mul_b = c3_ff; end  // cos lat1 * cos lat2
            2'd1:    begin mul_a = s1_ff; mul_b = s1_ff; end  // sin^2 dlng/2
            2'd2:    begin mul_a = t1_ff; mul_b = t2_ff; end
            default: begin mul_a = s0_ff; mul_b = s0_ff; end  // sin^2 dlat/2
         endcase
      end else if (state_ff == S_DIST_MUL) begin
         mul_a = MW'(theta_ff);
         mul_b = EARTH_DIAM;
      end
   end

   // degrees to radians in q30, half angles for the differences
   logic [4:0]           rad_sh;
   logic signed [PW-1:0] rad_full;
   logic signed [XW-1:0] rad_r;
   assign rad_sh   = k_ff[1] ? 5'd28 : 5'd29;
   assign rad_full = (mul_p + (PW'(1) <<< (rad_sh - 5'd1))) >>> rad_sh;
   assign rad_r    = rad_full[XW-1:0];

   // cordic stimulus
   assign cordic_ctrl.load      = (state_ff == S_RAD_FIX) || (state_ff == S_VEC_GO);
   assign cordic_ctrl.vectoring = (state_ff == S_VEC_GO);
   assign cx_in = XW'(rx_ff);
   assign cy_in = XW'(ry_ff);
   assign cz_in = ang_neg ? -rad_r : rad_r;

   // square roots of h and 1 - h, both scaled by 2^30
   assign sq_start = (state_ff == S_SQRT_GO);
   assign sq_v     = sq_sel_ff ? (SW'(Q30_ONE[RW-1:0] - h_ff) << 30) : (SW'(h_ff) << 30);

   // haversine sum and distance rounding
   logic signed [PW-1:0] prod_q30;
   logic signed [XW-1:0] h_sum;
   logic signed [PW-1:0] dist_full;
   assign prod_q30  = mul_p >>> 30;
   assign h_sum     = XW'(t1_ff) + XW'(prod_q30[MW-1:0]);
   assign dist_full = (mul_p + (PW'(1) <<< 29)) >>> 30;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_fire) state_in = S_FINISH;
         S_RAD_MUL:   state_in = S_RAD_FIX;
         S_RAD_FIX:   state_in = S_ROT_WAIT;
         S_ROT_WAIT:  if (cordic_stat.done) state_in = (k_ff == 2'd3) ? S_PROD_MUL : S_RAD_MUL;
         S_PROD_MUL:  state_in = S_PROD_WB;
         S_PROD_WB:   state_in = (pstep_ff == 2'd3) ? S_SQRT_GO : S_PROD_MUL;
         S_SQRT_GO:   state_in = S_SQRT_WAIT;
         S_SQRT_WAIT: if (sq_done) state_in = sq_sel_ff ? S_VEC_GO : S_SQRT_GO;
         S_VEC_GO:    state_in = S_VEC_WAIT;
         S_VEC_WAIT:  if (cordic_stat.done) state_in = S_DIST_MUL;
         S_DIST_MUL:  state_in = S_DIST_FIX;
         S_DIST_FIX:  state_in = S_FINISH;
         S_FINISH:    if (fin_fire) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
      // an update against a prior fix detours through the distance sequence
      if (detour)
         state_in = S_RAD_MUL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lock_ff      <= 1'b0;
         live_lat_ff  <= '0;
         live_lng_ff  <= '0;
         snap_lat_ff  <= '0;
         snap_lng_ff  <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         pstep_ff     <= '0;
         sq_sel_ff    <= 1'b0;
         jump_ff      <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_bus.valid && csr_bus.ready)
            limit_ff <= csr_bus.jump_limit_m;

         if (fin_fire)
            rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready)
            rsp_valid_ff <= 1'b0;

         if (req_fire) begin
            k_ff      <= '0;
            pstep_ff  <= '0;
            sq_sel_ff <= 1'b0;
            jump_ff   <= '0;
         end

         if (state_ff == S_ROT_WAIT && cordic_stat.done)
            k_ff <= k_ff + 2'd1;   // wraps to zero after the fourth angle
         if (state_ff == S_PROD_WB)
            pstep_ff <= pstep_ff + 2'd1;
         if (state_ff == S_SQRT_WAIT && sq_done)
            sq_sel_ff <= 1'b1;
         if (state_ff == S_DIST_FIX)
            jump_ff <= (dist_full > PW'(DIST_MAX)) ? DIST_MAX : dist_full[24:0];

         // commit on the response transfer into the output register
         if (fin_fire && !(jump_ff == '0 && need_dist && k_ff == 2'd0 && !sq_sel_ff)) begin
            unique case (op_ff)
               OP_UPDATE: begin
                  if (fix_valid && jump_ff <= {9'd0, limit_ff}) begin
                     live_lat_ff <= lat_ff;
                     live_lng_ff <= lng_ff;
                  end
               end
               OP_LOCK: begin
                  if (!lock_ff) begin
                     lock_ff     <= 1'b1;
                     snap_lat_ff <= live_lat_ff;
                     snap_lng_ff <= live_lng_ff;
                  end
               end
               OP_UNLOCK: lock_ff <= 1'b0;
               default:   ;
            endcase
         end
      end
   end

   // the finish state also serves as the no-distance shortcut: jump_ff is
   // still zero with the sequence counters clear on the first visit
   logic fin_commit;
   logic accept_fix;
   assign fin_commit = fin_fire && !(jump_ff == '0 && need_dist && k_ff == 2'd0 && !sq_sel_ff);
   assign accept_fix = fix_valid && (jump_ff <= {9'd0, limit_ff});

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_bus.operation;
         lat_ff <= req_bus.lat_in;
         lng_ff <= req_bus.lng_in;
      end

      if (state_ff == S_ROT_WAIT && cordic_stat.done) begin
         case (k_ff)
            2'd0:    s0_ff <= c_sin[MW-1:0];
            2'd1:    s1_ff <= c_sin[MW-1:0];
            2'd2:    c2_ff <= c_cos[MW-1:0];
            default: c3_ff <= c_cos[MW-1:0];
         endcase
      end

      if (state_ff == S_PROD_WB) begin
         case (pstep_ff)
            2'd0:    t1_ff <= prod_q30[MW-1:0];
            2'd1:    t2_ff <= prod_q30[MW-1:0];
            2'd2:    t1_ff <= prod_q30[MW-1:0];
            default: begin
               if (h_sum < 0)
                  h_ff <= '0;
               else if (h_sum > Q30_ONE)
                  h_ff <= Q30_ONE[RW-1:0];
               else
                  h_ff <= h_sum[RW-1:0];
            end
         endcase
      end

      if (state_ff == S_SQRT_WAIT && sq_done) begin
         if (sq_sel_ff)
            rx_ff <= sq_root;
         else
            ry_ff <= sq_root;
      end

      // central half angle clamped to [0, pi/2]
      if (state_ff == S_VEC_WAIT && cordic_stat.done) begin
         if (c_angle < 0)
            theta_ff <= '0;
         else if (c_angle > Q30_HALF_PI)
            theta_ff <= Q30_HALF_PI[30:0];
         else
            theta_ff <= c_angle[30:0];
      end

      if (fin_commit) begin
         rsp_jump_ff <= jump_ff;
         if (op_ff == OP_UPDATE) begin
            if (!fix_valid)
               rsp_status_ff <= ST_INVALID;
            else if (accept_fix)
               rsp_status_ff <= ST_ACCEPT;
            else
               rsp_status_ff <= ST_JUMP;
         end else begin
            rsp_status_ff <= ST_NOP;
         end
         // effective position after the step
         if (op_ff == OP_UNLOCK) begin
            rsp_lock_ff <= 1'b0;
            rsp_lat_ff  <= live_lat_ff;
            rsp_lng_ff  <= live_lng_ff;
         end else if (lock_ff) begin
            rsp_lock_ff <= 1'b1;
            rsp_lat_ff  <= snap_lat_ff;
            rsp_lng_ff  <= snap_lng_ff;
         end else if (op_ff == OP_UPDATE && accept_fix) begin
            rsp_lock_ff <= 1'b0;
            rsp_lat_ff  <= lat_ff;
            rsp_lng_ff  <= lng_ff;
         end else begin
            rsp_lock_ff <= (op_ff == OP_LOCK);
            rsp_lat_ff  <= live_lat_ff;
            rsp_lng_ff  <= live_lng_ff;
         end
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.eff_lat   = rsp_lat_ff;
   assign rsp_bus.eff_lng   = rsp_lng_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.is_locked = rsp_lock_ff;
   assign rsp_bus.jump_m    = rsp_jump_ff;

   // distance never exceeds half the circumference
   a_jump_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.jump_m <= DIST_MAX)
      else $error("jump distance above saturation");

   // no distance reported unless a fix was judged on it
   a_jump_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status == ST_INVALID || rsp_bus.status == ST_NOP)
      |-> rsp_bus.jump_m == '0)
      else $error("distance reported for a step without one");

   // shared units are quiet whenever a new request can be taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !cordic_stat.busy && !sq_busy)
      else $error("shared unit busy while idle");

endmodule
